// File: rtl/msif_pkg.sv
// ----------------------------------------------------------------------------
// msif_pkg
// Shared types, select codes and helpers for the MSI interrupt file.
// ----------------------------------------------------------------------------
`default_nettype none

package msif_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_FIND,
        S_TOP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_MSI   = 2'd2,
        REQ_CLAIM = 2'd3
    } t_req;

    localparam logic [11:0] SEL_DELIVERY  = 12'h070;
    localparam logic [11:0] SEL_THRESHOLD = 12'h072;
    // Upper six select bits of the pending (0x80-0xBF) and enable (0xC0-0xFF) blocks.
    localparam logic [5:0]  SEL_PEND_BLK  = 6'h02;
    localparam logic [5:0]  SEL_ENAB_BLK  = 6'h03;
    localparam logic [15:0] ID_MASK       = 16'hFFFF;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] pos;
        pos = 5'd0;
        for (int k = 31; k >= 0; k--) begin
            if (v[k]) begin
                pos = 5'(k);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// File: rtl/msif_word_ram.sv
// ----------------------------------------------------------------------------
// msif_word_ram
// Word memory with registered read and a valid bit per entry; an entry not
// written since reset reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module msif_word_ram #(
    parameter int WORDS = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0]      r_mem [WORDS];
    logic [WORDS-1:0] r_vld;
    logic [31:0]      r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 32'd0;

endmodule

`default_nettype wire

// File: rtl/msi_interrupt_file_top.sv
// ----------------------------------------------------------------------------
// msi_interrupt_file_top
// Interrupt file for message-signalled interrupts: pending and enable words
// in memories, a per-word summary vector, delivery bit and threshold.
// ----------------------------------------------------------------------------
//  channel  | valid    | ready    | payload
//  request  | i_valid  | o_ready  | i_req_type, i_select, i_write_data, i_interrupt_id
//  result   | o_valid  | i_ready  | o_read_data, o_top_interrupt, o_interrupt_signalled
//
// One item at a time for every kind: reads, writes and messages pass through
// word read, modify/write, summary search and top word read, and a claim
// through top search and clear, then a second search; the result beat is
// then handed off.
// Reset is synchronous; all words read as zero after reset with no clearing pass.
// A stalled result holds the block in its output state until taken.
`default_nettype none

module msi_interrupt_file_top
    import msif_pkg::*;
#(
    parameter int WORDS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_select,
    input  wire logic [31:0] i_write_data,
    input  wire logic [15:0] i_interrupt_id,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_read_data,
    output logic [31:0]      o_top_interrupt,
    output logic             o_interrupt_signalled
);

    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ID_LIM = WORDS * 32;

    t_state r_state, n_state;

    logic [1:0]  r_kind;
    logic [11:0] r_sel;
    logic [31:0] r_data;
    logic [15:0] r_id;
    logic        r_claimed;
    logic        r_deliv;
    logic [31:0] r_thr;
    logic [WORDS-1:0] r_sum;
    logic [AW-1:0]    r_fw;
    logic             r_any;
    logic [31:0] r_rd;
    logic [31:0] r_out_rd;
    logic [31:0] r_out_top;
    logic        r_out_sig;

    logic [31:0] p_q, e_q;
    logic        is_pend, is_enab, in_range, msi_ok;
    logic [10:0] msi_word;
    logic [AW-1:0] acc_addr, find_w, raddr;
    logic        pend_we, enab_we;
    logic [AW-1:0] pend_waddr;
    logic [31:0] pend_wdata;
    logic [31:0] new_p, new_e, acc_mask, top_mask, live;
    logic [4:0]  top_bit;
    logic [15:0] cand_id, top_id;
    logic [31:0] clr_p;
    logic [31:0] rd_val;

    // Decode of the latched request.
    always_comb begin
        is_pend  = (r_sel[11:6] == SEL_PEND_BLK);
        is_enab  = (r_sel[11:6] == SEL_ENAB_BLK);
        in_range = (7'({1'b0, r_sel[5:0]}) < 7'(WORDS));
        msi_ok   = (r_id != 16'd0) && (17'({1'b0, r_id}) < 17'(ID_LIM));
        msi_word = r_id[15:5];
        acc_addr = (r_kind == REQ_MSI) ? msi_word[AW-1:0] : r_sel[AW-1:0];
        acc_mask = (acc_addr == '0) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
    end

    // Lowest word with a live candidate.
    always_comb begin
        find_w = '0;
        for (int k = WORDS - 1; k >= 0; k--) begin
            if (r_sum[k]) begin
                find_w = AW'(k);
            end
        end
    end

    // Top interrupt from the word read back after the search.
    always_comb begin
        top_mask = (r_fw == '0) ? 32'hFFFF_FFFE : 32'hFFFF_FFFF;
        live     = p_q & e_q & top_mask;
        top_bit  = lowest_bit(live);
        cand_id  = (16'(r_fw) << 5) | 16'(top_bit);
        if (r_deliv && r_any && ((r_thr == 32'd0) || ({16'd0, cand_id} < r_thr))) begin
            top_id = cand_id & ID_MASK;
        end else begin
            top_id = 16'd0;
        end
        clr_p = p_q & ~(32'd1 << top_bit);
    end

    // Register read value.
    always_comb begin
        if (r_sel == SEL_DELIVERY) begin
            rd_val = {31'd0, r_deliv};
        end else if (r_sel == SEL_THRESHOLD) begin
            rd_val = r_thr;
        end else if (is_pend && in_range) begin
            rd_val = p_q;
        end else if (is_enab && in_range) begin
            rd_val = e_q;
        end else begin
            rd_val = 32'd0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_req'(i_req_type) == REQ_CLAIM) ? S_FIND : S_RD;
                end
            end
            S_RD:   n_state = S_MOD;
            S_MOD:  n_state = S_FIND;
            S_FIND: n_state = S_TOP;
            S_TOP:  n_state = (r_kind == REQ_CLAIM && !r_claimed) ? S_FIND : S_OUT;
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control per state.
    always_comb begin
        pend_we    = 1'b0;
        enab_we    = 1'b0;
        pend_waddr = acc_addr;
        pend_wdata = r_data;
        raddr      = (r_state == S_FIND) ? find_w : acc_addr;
        unique case (r_state)
            S_MOD: begin
                if (r_kind == REQ_WRITE) begin
                    pend_we = is_pend && in_range;
                    enab_we = is_enab && in_range;
                end else if (r_kind == REQ_MSI) begin
                    pend_we    = msi_ok;
                    pend_wdata = p_q | (32'd1 << r_id[4:0]);
                end
            end
            S_TOP: begin
                if (r_kind == REQ_CLAIM && !r_claimed && top_id != 16'd0) begin
                    pend_we    = 1'b1;
                    pend_waddr = r_fw;
                    pend_wdata = clr_p;
                end
            end
            default: ;
        endcase
        new_p = pend_we ? pend_wdata : p_q;
        new_e = enab_we ? r_data : e_q;
    end

    msif_word_ram #(.WORDS(WORDS), .AW(AW)) u_pend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (raddr),
        .o_rdata (p_q)
    );

    msif_word_ram #(.WORDS(WORDS), .AW(AW)) u_enab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (enab_we),
        .i_waddr (acc_addr),
        .i_wdata (r_data),
        .i_raddr (raddr),
        .o_rdata (e_q)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_req_type;
            r_sel  <= i_select;
            r_data <= i_write_data;
            r_id   <= i_interrupt_id;
            r_rd   <= 32'd0;
        end
        if (r_state == S_MOD && r_kind == REQ_READ) begin
            r_rd <= rd_val;
        end
        if (r_state == S_FIND) begin
            r_fw  <= find_w;
            r_any <= |r_sum;
        end
        if (r_state == S_TOP) begin
            r_out_rd  <= r_rd;
            r_out_top <= {top_id, top_id};
            r_out_sig <= (top_id != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_claimed <= 1'b0;
            r_deliv   <= 1'b0;
            r_thr     <= 32'd0;
            r_sum     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_claimed <= 1'b0;
            end
            if (r_state == S_TOP) begin
                r_claimed <= 1'b1;
            end
            if (r_state == S_MOD && r_kind == REQ_WRITE) begin
                if (r_sel == SEL_DELIVERY) begin
                    r_deliv <= r_data[0];
                end else if (r_sel == SEL_THRESHOLD) begin
                    r_thr <= r_data;
                end
            end
            // Keep the summary bit of a rewritten word in step with its contents.
            if (r_state == S_MOD && (pend_we || enab_we)) begin
                r_sum[acc_addr] <= |(new_p & new_e & acc_mask);
            end else if (r_state == S_TOP && pend_we) begin
                r_sum[r_fw] <= |(clr_p & e_q & top_mask);
            end
        end
    end

    assign o_ready               = (r_state == S_IDLE);
    assign o_valid               = (r_state == S_OUT);
    assign o_read_data           = r_out_rd;
    assign o_top_interrupt       = r_out_top;
    assign o_interrupt_signalled = r_out_sig;

    a_sig_matches_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_interrupt_signalled == (o_top_interrupt != 32'd0)))
        else $error("signalled flag disagrees with top interrupt");

    a_top_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_top_interrupt[31:16] == o_top_interrupt[15:0]))
        else $error("top interrupt halves differ");

    a_no_rd_on_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_kind != REQ_READ) |-> (o_read_data == 32'd0))
        else $error("read data nonzero for a non-read request");

    a_claim_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOP && r_claimed) |-> !pend_we)
        else $error("second pending clear in one claim");

endmodule

`default_nettype wire
